// ----- rtl/ked_pkg.sv -----
`timescale 1ns / 1ps

package ked_pkg;

  localparam int KEYS       = 4;
  localparam int LEVEL_BITS = 4;
  localparam int KEY_W      = $clog2(KEYS);
  localparam int FLAG_W     = 7;
  localparam int SEL_W      = 3;
  localparam int TIMER_W    = 16;
  localparam int PERIOD_W   = 8;
  localparam int CFG_W      = 16;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  // flag bit positions, same numbering as flag_select
  localparam logic [SEL_W-1:0] FLAG_HOLD   = 3'd0;
  localparam logic [SEL_W-1:0] FLAG_DOWN   = 3'd1;
  localparam logic [SEL_W-1:0] FLAG_UP     = 3'd2;
  localparam logic [SEL_W-1:0] FLAG_SINGLE = 3'd3;
  localparam logic [SEL_W-1:0] FLAG_DOUBLE = 3'd4;
  localparam logic [SEL_W-1:0] FLAG_LONG   = 3'd5;
  localparam logic [SEL_W-1:0] FLAG_REPEAT = 3'd6;

  localparam logic [PERIOD_W-1:0] DEBOUNCE_RESET = 8'd20;
  localparam logic [TIMER_W-1:0]  LONG_RESET     = 16'd1000;
  localparam logic [TIMER_W-1:0]  REPEAT_RESET   = 16'd100;
  localparam logic [TIMER_W-1:0]  DOUBLE_RESET   = 16'd0;

  typedef logic [FLAG_W-1:0] flags_t;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_CHECK = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_REPEAT   = 2'd2,
    REG_DOUBLE   = 2'd3
  } cfg_reg_t;

  // broadcast control from the front end to every lane
  typedef struct packed {
    logic tick;
    logic sample;
    logic clear_all;
  } lane_ctl_t;

  typedef struct packed {
    logic [TIMER_W-1:0] long_time;
    logic [TIMER_W-1:0] repeat_time;
    logic [TIMER_W-1:0] double_time;
  } timing_t;

endpackage

// ----- rtl/ked_lane.sv -----
`timescale 1ns / 1ps

module ked_lane (
  input  logic                clk,
  input  logic                rst,
  input  ked_pkg::lane_ctl_t  ctl,
  input  ked_pkg::timing_t    timing,
  input  logic                level,     // raw pin, low = pressed
  input  ked_pkg::flags_t     clr_mask,  // flags cleared by a check
  output ked_pkg::flags_t     flags,
  output ked_pkg::flags_t     flags_next
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_PRESS   = 3'd1,
    ST_RELEASE = 3'd2,
    ST_DOUBLE  = 3'd3,
    ST_REPEAT  = 3'd4
  } state_t;

  state_t                          state, state_next;
  logic [ked_pkg::TIMER_W-1:0]     timer, timer_next;
  logic                            pressed_now;
  logic                            now;
  logic [ked_pkg::TIMER_W-1:0]     timer_dec;

  assign now = ~level;

  // edges compare the new level with the last sampled one
  always_comb begin
    timer_dec  = (timer != '0) ? timer - 1'b1 : timer;
    state_next = state;
    timer_next = timer;
    flags_next = flags;
    if (ctl.tick) begin
      timer_next = timer_dec;
      if (ctl.sample) begin
        flags_next[ked_pkg::FLAG_HOLD] = now;
        if (now && !pressed_now) flags_next[ked_pkg::FLAG_DOWN] = 1'b1;
        if (!now && pressed_now) flags_next[ked_pkg::FLAG_UP] = 1'b1;
        unique case (state)
          ST_IDLE: begin
            if (now) begin
              timer_next = timing.long_time;
              state_next = ST_PRESS;
            end
          end
          ST_PRESS: begin
            if (!now) begin
              timer_next = timing.double_time;
              state_next = ST_RELEASE;
            end else if (timer_dec == '0) begin
              timer_next = timing.repeat_time;
              flags_next[ked_pkg::FLAG_LONG] = 1'b1;
              state_next = ST_REPEAT;
            end
          end
          ST_RELEASE: begin
            if (now) begin
              flags_next[ked_pkg::FLAG_DOUBLE] = 1'b1;
              state_next = ST_DOUBLE;
            end else if (timer_dec == '0) begin
              flags_next[ked_pkg::FLAG_SINGLE] = 1'b1;
              state_next = ST_IDLE;
            end
          end
          ST_DOUBLE: begin
            if (!now) state_next = ST_IDLE;
          end
          ST_REPEAT: begin
            if (!now) begin
              state_next = ST_IDLE;
            end else if (timer_dec == '0) begin
              timer_next = timing.repeat_time;
              flags_next[ked_pkg::FLAG_REPEAT] = 1'b1;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
    end else if (ctl.clear_all) begin
      flags_next = '0;
    end else begin
      flags_next = flags & ~clr_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      timer       <= '0;
      pressed_now <= 1'b0;
      flags       <= '0;
    end else begin
      state <= state_next;
      timer <= timer_next;
      flags <= flags_next;
      if (ctl.tick && ctl.sample) begin
        pressed_now <= now;
      end
    end
  end

endmodule

// ----- rtl/ked_merge.sv -----
`timescale 1ns / 1ps

module ked_merge (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      accept,
  input  logic                                      check,
  input  logic [ked_pkg::KEY_W-1:0]                 key_index,
  input  logic [ked_pkg::SEL_W-1:0]                 flag_select,
  input  logic [ked_pkg::KEYS-1:0][ked_pkg::FLAG_W-1:0] lane_flags,
  input  logic [ked_pkg::KEYS-1:0][ked_pkg::FLAG_W-1:0] lane_flags_next,
  output logic                                      in_ready,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [ked_pkg::OUT_DATA_W-1:0]            m_tdata
);

  logic                               key_ok;
  logic [ked_pkg::FLAG_W:0]           cur_ext;
  logic                               hit;
  ked_pkg::flags_t                    sel_flags;
  logic [ked_pkg::OUT_DATA_W-1:0]     result;
  logic                               skid_valid;
  logic [ked_pkg::OUT_DATA_W-1:0]     skid_data;

  assign key_ok    = int'(key_index) < ked_pkg::KEYS;
  assign cur_ext   = {1'b0, lane_flags[key_index]};
  assign hit       = check && key_ok && cur_ext[flag_select];
  assign sel_flags = key_ok ? lane_flags_next[key_index] : '0;
  assign result    = {sel_flags, hit};

  assign in_ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !m_tvalid) begin
      if (skid_valid) begin
        m_tdata    <= skid_data;
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else if (accept) begin
        m_tdata  <= result;
        m_tvalid <= 1'b1;
      end else begin
        m_tvalid <= 1'b0;
      end
    end else if (accept) begin
      skid_data  <= result;
      skid_valid <= 1'b1;
    end
  end

endmodule

// ----- rtl/key_event_detector.sv -----
`timescale 1ns / 1ps
// An accepted result is registered on m_tdata, or in the skid while the output stalls.
// Throughput: one transaction per cycle while s_tready is high; one lane per key, in step.
// A two-deep output stage (register plus skid) keeps s_tready high while one result waits.
// Reset (rst, synchronous, high): flags, timers, key machines and the sample counter clear;
// registers return to debounce 20, long 1000, repeat 100, double 0.

module key_event_detector (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [ked_pkg::IN_DATA_W-1:0]     s_tdata,  // key_levels[3:0], key_index[5:4],
                                                      // flag_select[8:6], zero pad
  input  logic [1:0]                        s_tuser,  // kind[1:0]
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [ked_pkg::OUT_DATA_W-1:0]    m_tdata,  // flag_hit[0], key_flags[7:1]
  // register write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [ked_pkg::CFG_W-1:0]         cfg_data
);

  // field unpack
  logic [ked_pkg::LEVEL_BITS-1:0] key_levels;
  logic [ked_pkg::KEY_W-1:0]      key_index;
  logic [ked_pkg::SEL_W-1:0]      flag_select;
  ked_pkg::kind_t                 kind;

  assign key_levels  = s_tdata[3:0];
  assign key_index   = s_tdata[5:4];
  assign flag_select = s_tdata[8:6];
  assign kind        = ked_pkg::kind_t'(s_tuser);

  logic s_acc;
  assign s_acc = s_tvalid && s_tready;

  // configuration registers; writes are always taken
  logic [ked_pkg::PERIOD_W-1:0] debounce_period;
  ked_pkg::timing_t             timing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_period    <= ked_pkg::DEBOUNCE_RESET;
      timing.long_time   <= ked_pkg::LONG_RESET;
      timing.repeat_time <= ked_pkg::REPEAT_RESET;
      timing.double_time <= ked_pkg::DOUBLE_RESET;
    end else if (cfg_valid) begin
      unique case (ked_pkg::cfg_reg_t'(cfg_index))
        ked_pkg::REG_DEBOUNCE: debounce_period <= cfg_data[ked_pkg::PERIOD_W-1:0];
        ked_pkg::REG_LONG:     timing.long_time   <= cfg_data;
        ked_pkg::REG_REPEAT:   timing.repeat_time <= cfg_data;
        ked_pkg::REG_DOUBLE:   timing.double_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // debounce sample counter (8 bits): samples and restarts once it reaches the period
  logic [ked_pkg::PERIOD_W-1:0] sample_counter, counter_inc;
  logic                         tick, sample;

  assign tick        = s_acc && (kind == ked_pkg::KIND_TICK);
  assign counter_inc = sample_counter + 1'b1;
  assign sample      = counter_inc >= debounce_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
    end else if (tick) begin
      sample_counter <= sample ? '0 : counter_inc;
    end
  end

  ked_pkg::lane_ctl_t ctl;
  logic               check;

  assign check         = s_acc && (kind == ked_pkg::KIND_CHECK);
  assign ctl.tick      = tick;
  assign ctl.sample    = sample;
  assign ctl.clear_all = s_acc && (kind == ked_pkg::KIND_CLEAR);

  // a check clears the selected flag of the selected key, except hold and select seven
  logic sel_clears;
  assign sel_clears = (flag_select != ked_pkg::FLAG_HOLD) &&
                      (int'(flag_select) < ked_pkg::FLAG_W);

  logic [ked_pkg::KEYS-1:0][ked_pkg::FLAG_W-1:0] lane_flags, lane_flags_next;

  for (genvar k = 0; k < ked_pkg::KEYS; k++) begin : g_lane
    logic            level;
    ked_pkg::flags_t clr_mask;

    // keys beyond the level vector read as released
    if (k < ked_pkg::LEVEL_BITS) begin : g_pin
      assign level = key_levels[k];
    end else begin : g_nopin
      assign level = 1'b1;
    end

    assign clr_mask = (check && sel_clears && (int'(key_index) == k)) ?
                      ked_pkg::flags_t'(1) << flag_select : '0;

    ked_lane u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .timing     (timing),
      .level      (level),
      .clr_mask   (clr_mask),
      .flags      (lane_flags[k]),
      .flags_next (lane_flags_next[k])
    );
  end

  // select the asked key, form the result, hold it in the output stage
  ked_merge u_merge (
    .clk             (clk),
    .rst             (rst),
    .accept          (s_acc),
    .check           (check),
    .key_index       (key_index),
    .flag_select     (flag_select),
    .lane_flags      (lane_flags),
    .lane_flags_next (lane_flags_next),
    .in_ready        (s_tready),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata)
  );

`ifndef SYNTH
  // a clear transaction leaves every key with no flags
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.clear_all |=> lane_flags == '0)
    else $error("flags left after clear");

  // only ticks move the debounce counter
  a_counter_ticks_only: assert property (@(posedge clk) disable iff (rst)
    !tick |=> $stable(sample_counter))
    else $error("sample counter moved without a tick");

  // a sampling tick restarts the debounce count
  a_sample_restarts: assert property (@(posedge clk) disable iff (rst)
    tick && sample |=> sample_counter == '0)
    else $error("sample counter not restarted");

  // a hit is only reported for a check transaction entering an empty output register
  a_hit_on_check: assert property (@(posedge clk) disable iff (rst)
    s_acc && !check && !m_tvalid |=> m_tdata[0] == 1'b0)
    else $error("flag hit on a non-check transaction");
`endif

endmodule

// ----- bench/key_event_detector_check.sv -----
`timescale 1ns / 1ps

module key_event_detector_check
  import ked_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]            s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  output int                    errors,
  output int                    outstanding
);

  typedef enum logic [2:0] {
    KEY_IDLE,
    KEY_TIMING_LONG,
    KEY_WAIT_DOUBLE,
    KEY_WAIT_RELEASE,
    KEY_REPEATING
  } key_phase_t;

  typedef struct packed {
    logic   hit;
    flags_t flags;
  } key_report_t;

  logic [PERIOD_W-1:0] debounce_q;
  logic [TIMER_W-1:0]  long_q;
  logic [TIMER_W-1:0]  repeat_q;
  logic [TIMER_W-1:0]  double_q;

  logic [PERIOD_W-1:0] tick_count;
  logic                held_now  [KEYS];
  logic                held_prev [KEYS];
  key_phase_t          key_phase [KEYS];
  logic [TIMER_W-1:0]  countdown [KEYS];
  flags_t              key_flags_q [KEYS];

  key_report_t         report_q [$];
  int                  fail_count = 0;
  int                  pending_count = 0;

  assign errors      = fail_count;
  assign outstanding = pending_count;

  // debounced sample of all keys: level flags, edges, then the event machine
  function automatic void sample_levels(input logic [LEVEL_BITS-1:0] levels);
    flags_t f;
    logic   now;
    for (int k = 0; k < KEYS; k++) begin
      now = !levels[k];
      f = key_flags_q[k];
      held_prev[k] = held_now[k];
      held_now[k]  = now;
      f[FLAG_HOLD] = now;
      if (now && !held_prev[k]) f[FLAG_DOWN] = 1'b1;
      if (!now && held_prev[k]) f[FLAG_UP] = 1'b1;
      case (key_phase[k])
        KEY_IDLE: begin
          if (now) begin
            countdown[k] = long_q;
            key_phase[k] = KEY_TIMING_LONG;
          end
        end
        KEY_TIMING_LONG: begin
          if (!now) begin
            countdown[k] = double_q;
            key_phase[k] = KEY_WAIT_DOUBLE;
          end else if (countdown[k] == '0) begin
            countdown[k] = repeat_q;
            f[FLAG_LONG] = 1'b1;
            key_phase[k] = KEY_REPEATING;
          end
        end
        KEY_WAIT_DOUBLE: begin
          if (now) begin
            f[FLAG_DOUBLE] = 1'b1;
            key_phase[k] = KEY_WAIT_RELEASE;
          end else if (countdown[k] == '0) begin
            f[FLAG_SINGLE] = 1'b1;
            key_phase[k] = KEY_IDLE;
          end
        end
        KEY_WAIT_RELEASE: begin
          if (!now) key_phase[k] = KEY_IDLE;
        end
        KEY_REPEATING: begin
          if (!now) begin
            key_phase[k] = KEY_IDLE;
          end else if (countdown[k] == '0) begin
            countdown[k] = repeat_q;
            f[FLAG_REPEAT] = 1'b1;
          end
        end
        default: key_phase[k] = KEY_IDLE;
      endcase
      key_flags_q[k] = f;
    end
  endfunction

  function automatic key_report_t step_keys(input logic [1:0] kind,
                                            input logic [LEVEL_BITS-1:0] levels,
                                            input logic [KEY_W-1:0] idx,
                                            input logic [SEL_W-1:0] sel);
    logic hit;
    hit = 1'b0;
    case (kind)
      KIND_TICK: begin
        for (int k = 0; k < KEYS; k++)
          if (countdown[k] != '0) countdown[k] = countdown[k] - 1'b1;
        tick_count = tick_count + 1'b1;
        if (tick_count >= debounce_q) begin
          tick_count = '0;
          sample_levels(levels);
        end
      end
      KIND_CHECK: begin
        // select seven names no flag; hold is reported but never cleared
        if (sel < FLAG_W && key_flags_q[idx][sel]) begin
          hit = 1'b1;
          if (sel != FLAG_HOLD) key_flags_q[idx][sel] = 1'b0;
        end
      end
      KIND_CLEAR: begin
        for (int k = 0; k < KEYS; k++) key_flags_q[k] = '0;
      end
      default: ;
    endcase
    return '{hit, key_flags_q[idx]};
  endfunction

  always @(posedge clk) begin
    key_report_t want;
    if (rst) begin
      debounce_q = DEBOUNCE_RESET;
      long_q     = LONG_RESET;
      repeat_q   = REPEAT_RESET;
      double_q   = DOUBLE_RESET;
      tick_count = '0;
      for (int k = 0; k < KEYS; k++) begin
        held_now[k]    = 1'b0;
        held_prev[k]   = 1'b0;
        key_phase[k]   = KEY_IDLE;
        countdown[k]   = '0;
        key_flags_q[k] = '0;
      end
      report_q.delete();
    end else begin
      // results leave before this edge's input can have produced one
      if (m_tvalid && m_tready) begin
        if (report_q.size() == 0) begin
          fail_count++;
          $error("result transaction with no prediction pending: tdata %h", m_tdata);
        end else begin
          want = report_q.pop_front();
          if (m_tdata[0] !== want.hit) begin
            fail_count++;
            $error("flag_hit: expected %0d, got %0d", want.hit, m_tdata[0]);
          end
          if (m_tdata[FLAG_W:1] !== want.flags) begin
            fail_count++;
            $error("key_flags: expected %b, got %b", want.flags, m_tdata[FLAG_W:1]);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_DEBOUNCE: debounce_q = cfg_data[PERIOD_W-1:0];
          REG_LONG:     long_q     = cfg_data[TIMER_W-1:0];
          REG_REPEAT:   repeat_q   = cfg_data[TIMER_W-1:0];
          REG_DOUBLE:   double_q   = cfg_data[TIMER_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        report_q.push_back(step_keys(s_tuser,
                                     s_tdata[LEVEL_BITS-1:0],
                                     s_tdata[LEVEL_BITS +: KEY_W],
                                     s_tdata[LEVEL_BITS+KEY_W +: SEL_W]));
    end
    pending_count = report_q.size();
  end

endmodule

// ----- bench/key_event_detector_test.sv -----
`timescale 1ns / 1ps

module key_event_detector_test;
  import ked_pkg::*;

  // kind code the block must ignore, and a flag select that names no flag
  localparam logic [1:0]       KIND_UNUSED = 2'd3;
  localparam logic [SEL_W-1:0] SEL_NONE    = 3'd7;
  // cycles without any transaction before the run is declared hung;
  // worst honest stretch is the longest send gap plus the longest stall
  localparam int               IDLE_LIMIT  = 500;
  // gap mode is redrawn every this many transactions per side
  localparam int               MODE_SPAN   = 30;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic [1:0]            s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [1:0]            cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data  = '0;

  int                    errors;
  int                    outstanding;
  int                    idle_cycles = 0;
  int                    send_mode   = 0;
  int                    sent_count  = 0;
  int                    take_mode   = 0;
  // key pattern for random ticks: 1 = held down (pin level low)
  logic [LEVEL_BITS-1:0] held_keys   = '0;

  key_event_detector dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  key_event_detector_check checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // mode 0: back to back, mode 1: gap drawn for every item, mode 2: occasional gap
  function automatic int draw_gap(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 17);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 17) : 0;
    endcase
  endfunction

  // one input transaction; valid stays up across back-to-back items
  task automatic send_item(input logic [1:0] kind,
                           input logic [LEVEL_BITS-1:0] levels,
                           input logic [KEY_W-1:0] idx,
                           input logic [SEL_W-1:0] sel);
    int                   gap;
    logic [IN_DATA_W-1:0] word;
    if (sent_count % MODE_SPAN == 0) send_mode = $urandom_range(0, 2);
    sent_count++;
    gap = draw_gap(send_mode);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word = '0;
    word[LEVEL_BITS-1:0]            = levels;
    word[LEVEL_BITS +: KEY_W]       = idx;
    word[LEVEL_BITS+KEY_W +: SEL_W] = sel;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending and wait for every predicted result; the block answers
  // each transaction, so once the last result is out it is idle
  task automatic finish_phase();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t which, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_timing(input logic [PERIOD_W-1:0] period,
                            input logic [TIMER_W-1:0]  long_ticks,
                            input logic [TIMER_W-1:0]  repeat_ticks,
                            input logic [TIMER_W-1:0]  double_ticks);
    write_reg(REG_DEBOUNCE, CFG_W'(period));
    write_reg(REG_LONG, long_ticks);
    write_reg(REG_REPEAT, repeat_ticks);
    write_reg(REG_DOUBLE, double_ticks);
    cfg_valid <= 1'b0;
  endtask

  // mostly ticks that follow a slowly changing key pattern, so presses last
  // long enough to reach long, repeat, double and single events; some ticks
  // carry noise levels, and checks and clears are mixed in
  task automatic run_random(input int count);
    int                    pick;
    logic [1:0]            kind;
    logic [LEVEL_BITS-1:0] levels;
    for (int n = 0; n < count; n++) begin
      pick   = $urandom_range(0, 99);
      levels = LEVEL_BITS'($urandom);
      if (pick < 68) begin
        kind = KIND_TICK;
        for (int k = 0; k < LEVEL_BITS; k++)
          if ($urandom_range(0, 6) == 0) held_keys[k] = ~held_keys[k];
        if ($urandom_range(0, 11) != 0) levels = ~held_keys;
      end else if (pick < 93) begin
        kind = KIND_CHECK;
      end else if (pick < 97) begin
        kind = KIND_CLEAR;
      end else begin
        kind = KIND_UNUSED;
      end
      send_item(kind, levels, KEY_W'($urandom_range(0, KEYS - 1)),
                SEL_W'($urandom_range(0, 7)));
    end
  endtask

  // result side: stalls drawn per transaction, ready held across accepts
  initial begin
    int gap;
    int taken;
    taken = 0;
    forever begin
      if (taken % MODE_SPAN == 0) take_mode = $urandom_range(0, 2);
      gap = draw_gap(take_mode);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  // hang detector: any accepted transaction on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset timing: a held tick far from the debounce count, a check with
    // no flag named, and the unused kind
    send_item(KIND_TICK, 4'h0, 0, FLAG_HOLD);
    send_item(KIND_CHECK, 4'hF, 3, SEL_NONE);
    send_item(KIND_UNUSED, 4'h5, 2, FLAG_REPEAT);
    finish_phase();

    // directed walk with every tick sampling and two-tick long press
    set_timing(8'd1, 16'd2, 16'd1, 16'd1);
    send_item(KIND_TICK, 4'hF, 0, FLAG_HOLD);
    send_item(KIND_TICK, 4'h0, 3, FLAG_UP);        // all keys go down
    send_item(KIND_CHECK, 4'hF, 0, FLAG_HOLD);     // hold hits, stays set
    send_item(KIND_CHECK, 4'h0, 0, FLAG_DOWN);
    send_item(KIND_CHECK, 4'hF, 0, FLAG_UP);
    send_item(KIND_CHECK, 4'hF, 0, SEL_NONE);
    send_item(KIND_CHECK, 4'hA, 3, FLAG_DOWN);
    send_item(KIND_TICK, 4'h0, 1, FLAG_HOLD);
    send_item(KIND_TICK, 4'h0, 0, FLAG_HOLD);      // long fires
    send_item(KIND_TICK, 4'h0, 0, FLAG_HOLD);      // first repeat
    send_item(KIND_CHECK, 4'hF, 0, FLAG_LONG);
    send_item(KIND_CHECK, 4'hF, 0, FLAG_REPEAT);
    send_item(KIND_TICK, 4'hF, 2, FLAG_HOLD);      // release, up edge
    send_item(KIND_CHECK, 4'hF, 2, FLAG_UP);
    send_item(KIND_TICK, 4'h0, 1, FLAG_HOLD);      // press, release, press: double
    send_item(KIND_TICK, 4'hF, 1, FLAG_HOLD);
    send_item(KIND_TICK, 4'h0, 1, FLAG_HOLD);
    send_item(KIND_CHECK, 4'hF, 1, FLAG_DOUBLE);
    send_item(KIND_TICK, 4'hF, 0, FLAG_HOLD);
    send_item(KIND_TICK, 4'h0, 0, FLAG_HOLD);      // press, release, wait: single
    send_item(KIND_TICK, 4'hF, 0, FLAG_HOLD);
    send_item(KIND_TICK, 4'hF, 0, FLAG_HOLD);
    send_item(KIND_CHECK, 4'hF, 0, FLAG_SINGLE);
    send_item(KIND_CLEAR, 4'h0, 3, FLAG_HOLD);
    send_item(KIND_CHECK, 4'hF, 3, FLAG_UP);
    finish_phase();

    set_timing(8'd1, 16'd6, 16'd2, 16'd4);
    run_random(120);
    finish_phase();

    // zero debounce samples on every tick; zero timers fire at once
    set_timing(8'd0, 16'd0, 16'd0, 16'd0);
    run_random(60);
    finish_phase();

    // top of every range: no sample lands, but the tick count climbs
    set_timing(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(40);
    finish_phase();

    // debounce now below the running count, so the next tick samples
    set_timing(8'd5, 16'd3, 16'd1, 16'd2);
    run_random(100);
    finish_phase();

    set_timing(8'd2, 16'd10, 16'd3, 16'd6);
    run_random(120);
    finish_phase();

    set_timing(8'd1, 16'd1, 16'd1, 16'd1);
    run_random(60);
    finish_phase();

    repeat (4) @(posedge clk);
    if (errors == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
